// ----- rtl/gso_pkg.sv -----
// Shared types, constants and the quarter-wave sine generator for the glide sub oscillator.
// No dependencies; imported by glide_sub_oscillator_unit.
package gso_pkg;

    // Field and register widths fixed by the interface
    localparam int STEP_W     = 31;
    localparam int COEFF_W    = 17;
    localparam int LEVEL_W    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int WAVE_W     = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Unity values for the coefficient (Q1.16) and the level (Q1.15)
    localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;

    // Waveform codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    // Full-scale waveform values in Q15
    localparam logic signed [WAVE_W-1:0] W_POS_ONE = 17'sd32768;
    localparam logic signed [WAVE_W-1:0] W_NEG_ONE = -17'sd32768;
    localparam logic signed [WAVE_W-1:0] W_ZERO    = 17'sd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLIDE_COEFF = 2'd0,
        CFG_WAVEFORM    = 2'd1,
        CFG_OCTAVE      = 2'd2,
        CFG_LEVEL       = 2'd3
    } t_cfg_reg;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(t * pi/2) in Q15 for t in [0,1] given in Q30; evaluated at elaboration only
    function automatic logic [WAVE_W-1:0] f_quarter_sine(input logic [63:0] t);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] q;
        th  = (t * HALF_PI_Q30) >> 30;
        x2  = (th * th) >> 30;
        acc = Q30_ONE;
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd156);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd110);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd72);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd42);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd20);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd6);
        s   = (th * acc) >> 30;
        q   = (s + 64'd16384) >> 15;
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        return q[WAVE_W-1:0];
    endfunction

endpackage

// ----- rtl/glide_sub_oscillator_unit.sv -----
// Throughput: one request per cycle while the output is not stalled, set by the step read-modify-write loop.
// Stalls on the output back up through four stages; the input is refused only when all are full.
// Reset (synchronous, active low) empties the pipeline, sets the step and phase to zero
// and restores the register defaults: coefficient unity, sine, no octave shift, unity level.
// Depends on gso_pkg for widths, codes and the sine generator.
module glide_sub_oscillator_unit
    import gso_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic        [STEP_W-1:0]     i_target_step,
    input  logic                         i_snap,
    // sample channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SAMPLE_W-1:0]   o_sample,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
    localparam int QUARTER   = SINE_SIZE / 4;
    localparam int SUM_W     = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    typedef logic signed [WAVE_W-1:0] t_sine_rom [SINE_SIZE];

    // Build the full-cycle sine table from the quarter wave
    function automatic t_sine_rom f_build_sine();
        t_sine_rom       rom;
        int              quad;
        int              rem;
        int              pos;
        logic [63:0]     t;
        logic [WAVE_W-1:0] v;
        for (int a = 0; a < SINE_SIZE; a++) begin
            quad = a >> (SINE_ADDR_BITS - 2);
            rem  = a & (QUARTER - 1);
            pos  = ((quad & 1) != 0) ? QUARTER - rem : rem;
            t    = 64'(pos) << (30 - (SINE_ADDR_BITS - 2));
            v    = f_quarter_sine(t);
            rom[a] = (quad >= 2) ? WAVE_W'(-int'(v)) : WAVE_W'(int'(v));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [COEFF_W-1:0] r_glide_coeff;
    logic        [1:0]         r_waveform;
    logic signed [1:0]         r_octave;
    logic        [LEVEL_W-1:0] r_level;

    assign o_cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glide_coeff <= COEFF_ONE;
            r_waveform    <= WAVE_SINE;
            r_octave      <= 2'sd0;
            r_level       <= LEVEL_ONE;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GLIDE_COEFF: r_glide_coeff <= i_cfg_data;
                CFG_WAVEFORM:    r_waveform    <= i_cfg_data[1:0];
                CFG_OCTAVE:      r_octave      <= $signed(i_cfg_data[1:0]);
                CFG_LEVEL:       r_level       <= i_cfg_data[LEVEL_W-1:0];
                default:         r_glide_coeff <= r_glide_coeff;
            endcase
        end
    end

    // Clamp the coefficient and level, turn a negative octave into a right shift
    logic [COEFF_W-1:0] coeff_eff;
    logic [LEVEL_W-1:0] level_eff;
    logic [1:0]         oct_shift;

    assign coeff_eff = (r_glide_coeff > COEFF_ONE) ? COEFF_ONE : r_glide_coeff;
    assign level_eff = (r_level > LEVEL_ONE) ? LEVEL_ONE : r_level;
    assign oct_shift = r_octave[1] ? 2'(~r_octave + 2'd1) : 2'd0;

    // ------------------------------------------------------------------
    // Pipeline flow control: stage A (step), B (phase), C (scale), O (output)
    // ------------------------------------------------------------------
    logic r_a_vld;
    logic r_b_vld;
    logic r_c_vld;
    logic r_o_vld;
    logic o_take;
    logic c_take;
    logic b_take;
    logic a_take;
    logic a_move;
    logic b_move;
    logic in_acc;

    assign o_take = !r_o_vld || i_out_ready;
    assign c_take = !r_c_vld || o_take;
    assign b_take = !r_b_vld || c_take;
    assign a_take = !r_a_vld || b_take;
    assign a_move = r_a_vld && b_take;
    assign b_move = r_b_vld && c_take;
    assign in_acc = i_in_valid && a_take;

    assign o_in_ready  = a_take;
    assign o_out_valid = r_o_vld;

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (a_take) begin
                r_a_vld <= i_in_valid;
            end
            if (b_take) begin
                r_b_vld <= r_a_vld;
            end
            if (c_take) begin
                r_c_vld <= r_b_vld;
            end
            if (o_take) begin
                r_o_vld <= r_c_vld;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: read-modify-write of the current step
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] r_a_target;
    logic              r_a_snap;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_target <= i_target_step;
            r_a_snap   <= i_snap;
        end
    end

    logic [STEP_W-1:0] r_step_mem [1];
    logic [STEP_W-1:0] r_step_rd;
    logic [STEP_W-1:0] r_step_wdat;
    logic              r_step_fwd;
    logic              r_step_init;
    logic [STEP_W-1:0] n_step;

    // Step memory: write on hand-over to stage B, read every cycle
    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_step_mem[0] <= n_step;
            r_step_wdat   <= n_step;
        end
        r_step_rd <= r_step_mem[0];
    end

    // Track the write just made and whether the entry holds data yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_fwd  <= 1'b0;
            r_step_init <= 1'b0;
        end else begin
            r_step_fwd <= a_move;
            if (a_move) begin
                r_step_init <= 1'b1;
            end
        end
    end

    logic [STEP_W-1:0]         cur_step;
    logic                      step_lt;
    logic [STEP_W-1:0]         step_mag;
    logic [STEP_W+COEFF_W-1:0] glide_prod;
    logic [STEP_W-1:0]         step_move;

    // Forward the last write over the stale read
    assign cur_step = r_step_fwd  ? r_step_wdat :
                      r_step_init ? r_step_rd   : '0;

    // Snap to or glide toward the target, at least one unit per sample when gliding
    always_comb begin
        step_lt    = cur_step < r_a_target;
        step_mag   = step_lt ? (r_a_target - cur_step) : (cur_step - r_a_target);
        glide_prod = (STEP_W+COEFF_W)'(step_mag) * (STEP_W+COEFF_W)'(coeff_eff);
        step_move  = glide_prod[STEP_W+15:16];
        if (step_move == '0) begin
            step_move = STEP_W'(1);
        end
        if (r_a_snap) begin
            n_step = r_a_target;
        end else if (cur_step == r_a_target) begin
            n_step = cur_step;
        end else if (step_lt) begin
            n_step = cur_step + step_move;
        end else begin
            n_step = cur_step - step_move;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: read-modify-write of the phase, waveform shape
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] r_b_step;

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_step <= n_step;
        end
    end

    logic [PHASE_BITS-1:0] r_phase_mem [1];
    logic [PHASE_BITS-1:0] r_phase_rd;
    logic [PHASE_BITS-1:0] r_phase_wdat;
    logic                  r_phase_fwd;
    logic                  r_phase_init;
    logic [PHASE_BITS-1:0] n_phase;

    // Phase memory: write on hand-over to stage C, read every cycle
    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_phase_mem[0] <= n_phase;
            r_phase_wdat   <= n_phase;
        end
        r_phase_rd <= r_phase_mem[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_fwd  <= 1'b0;
            r_phase_init <= 1'b0;
        end else begin
            r_phase_fwd <= b_move;
            if (b_move) begin
                r_phase_init <= 1'b1;
            end
        end
    end

    logic [PHASE_BITS-1:0]     cur_phase;
    logic [STEP_W-1:0]         step_sh;
    logic [SUM_W-1:0]          phase_sum;
    logic [15:0]               tri_h;
    logic [16:0]               tri_d;
    logic signed [17:0]        tri_val;
    logic                      sel_sine;
    logic signed [WAVE_W-1:0]  shape_w;
    logic [SINE_ADDR_BITS-1:0] sine_addr;

    assign cur_phase = r_phase_fwd  ? r_phase_wdat :
                       r_phase_init ? r_phase_rd   : '0;

    // Advance the phase by the octave-shifted step
    assign step_sh   = r_b_step >> oct_shift;
    assign phase_sum = SUM_W'(cur_phase) + SUM_W'(step_sh);
    assign n_phase   = phase_sum[PHASE_BITS-1:0];

    assign sine_addr = cur_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];

    // Triangle, square, silence or the sine select from the phase before the advance
    always_comb begin
        tri_h    = cur_phase[PHASE_BITS-1 -: 16];
        tri_d    = tri_h[15] ? (17'd65536 - {1'b0, tri_h}) : {1'b0, tri_h};
        tri_val  = $signed({tri_d, 1'b0}) - 18'sd32768;
        sel_sine = 1'b0;
        case (r_waveform)
            WAVE_SINE:     begin
                sel_sine = 1'b1;
                shape_w  = W_ZERO;
            end
            WAVE_TRIANGLE: shape_w = tri_val[WAVE_W-1:0];
            WAVE_SQUARE:   shape_w = cur_phase[PHASE_BITS-1] ? W_NEG_ONE : W_POS_ONE;
            default:       shape_w = W_ZERO;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage C: sine table read, level scaling, rounding, saturation
    // ------------------------------------------------------------------
    logic signed [WAVE_W-1:0] r_sine_q;
    logic signed [WAVE_W-1:0] r_c_shape;
    logic                     r_c_sel_sine;

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_sine_q     <= SINE_ROM[sine_addr];
            r_c_shape    <= shape_w;
            r_c_sel_sine <= sel_sine;
        end
    end

    logic signed [WAVE_W-1:0]   c_w;
    logic signed [33:0]         c_prod;
    logic signed [33:0]         c_round;
    logic signed [SAMPLE_W-1:0] n_sample;

    always_comb begin
        c_w     = r_c_sel_sine ? r_sine_q : r_c_shape;
        c_prod  = 34'(c_w) * $signed(34'(level_eff));
        c_round = (c_prod + 34'sd16384) >>> 15;
        if (c_round > 34'sd32767) begin
            n_sample = 16'sh7FFF;
        end else if (c_round < -34'sd32768) begin
            n_sample = -16'sh8000;
        end else begin
            n_sample = c_round[SAMPLE_W-1:0];
        end
    end

    // Output register: hold while the sample waits
    logic signed [SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (o_take && r_c_vld) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

// ----- test/tb_glide_sub_oscillator_unit.sv -----
// Testbench for glide_sub_oscillator_unit: directed and random requests with its own
// sample predictor, randomised idling on both channels and a long output hold-off.
// Depends on gso_pkg and the glide_sub_oscillator_unit RTL only.
module tb_glide_sub_oscillator_unit
    import gso_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_W     = 32;
    localparam int SINE_AW     = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    localparam logic [1:0] WAVE_UNUSED = 2'd3;
    // Octave register codes: two-bit signed, positive value acts as no shift
    localparam logic [1:0] OCT_NONE  = 2'd0;
    localparam logic [1:0] OCT_UP    = 2'd1;
    localparam logic [1:0] OCT_DOWN2 = 2'd2;
    localparam logic [1:0] OCT_DOWN1 = 2'd3;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic         [STEP_W-1:0]     i_target_step = '0;
    logic                          i_snap        = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic signed  [SAMPLE_W-1:0]   o_sample;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic         [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic         [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Predicted oscillator state and register copies
    logic [PHASE_W-1:0]  model_phase;
    logic [STEP_W-1:0]   model_step;
    logic [COEFF_W-1:0]  glide_coeff;
    logic [1:0]          wave_sel;
    logic [1:0]          oct_code;
    logic [LEVEL_W-1:0]  gain;
    int                  sine_rom [2**SINE_AW];

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    int mismatches    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    glide_sub_oscillator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_target_step (i_target_step),
        .i_snap        (i_snap),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // sin(t * pi/2) in Q15 for t in [0,1] as Q30, Taylor series evaluated by Horner
    function automatic int quarter_wave(input longint unsigned t);
        longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned th, x2, acc, q;
        th  = (t * 64'd1686629713) >> 30;
        x2  = (th * th) >> 30;
        acc = 64'd1073741824;
        for (int i = 0; i < 6; i++) begin
            acc = 64'd1073741824 - ((x2 * acc) >> 30) / divs[i];
        end
        q = (((th * acc) >> 30) + 64'd16384) >> 15;
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        return int'(q);
    endfunction

    // Advance the predicted step and phase by one request and return its sample
    function automatic logic signed [SAMPLE_W-1:0] next_sample(
        input logic [STEP_W-1:0] target,
        input logic              snap
    );
        longint unsigned coeff, lvl, gap, move, h, d;
        longint          w, res;
        int              shift;
        coeff = glide_coeff;
        if (coeff > COEFF_ONE) begin
            coeff = COEFF_ONE;
        end
        lvl = gain;
        if (lvl > LEVEL_ONE) begin
            lvl = LEVEL_ONE;
        end
        // snap or glide the step towards the target
        if (snap) begin
            model_step = target;
        end else if (model_step != target) begin
            gap  = (model_step < target) ? target - model_step : model_step - target;
            move = (gap * coeff) >> 16;
            if (move == 0) begin
                move = 1;
            end
            if (model_step < target) begin
                model_step = model_step + STEP_W'(move);
            end else begin
                model_step = model_step - STEP_W'(move);
            end
        end
        // read the waveform at the current phase
        case (wave_sel)
            WAVE_SINE: begin
                w = sine_rom[model_phase[PHASE_W-1 -: SINE_AW]];
            end
            WAVE_TRIANGLE: begin
                h = model_phase[PHASE_W-1 -: 16];
                d = (h < 32768) ? h : 65536 - h;
                w = longint'(2 * d) - 32768;
            end
            WAVE_SQUARE: begin
                w = model_phase[PHASE_W-1] ? -32768 : 32768;
            end
            default: begin
                w = 0;
            end
        endcase
        // scale by the level with rounding, then saturate
        res = (w * longint'(lvl) + 16384) >>> 15;
        if (res > 32767) begin
            res = 32767;
        end
        if (res < -32768) begin
            res = -32768;
        end
        case (oct_code)
            OCT_DOWN2: shift = 2;
            OCT_DOWN1: shift = 1;
            default:   shift = 0;
        endcase
        model_phase = model_phase + PHASE_W'(model_step >> shift);
        return res[SAMPLE_W-1:0];
    endfunction

    // Offer one request, hold it until accepted, then idle at random
    task automatic send_request(input logic [STEP_W-1:0] target, input logic snap);
        i_in_valid    <= 1'b1;
        i_target_step <= target;
        i_snap        <= snap;
        do @(posedge i_clk); while (!o_in_ready);
        pending_samples.push_back(next_sample(target, snap));
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop the request and wait until every sample is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register once the block is idle and mirror it in the predictor
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GLIDE_COEFF: glide_coeff = data[COEFF_W-1:0];
            CFG_WAVEFORM:    wave_sel    = data[1:0];
            CFG_OCTAVE:      oct_code    = data[1:0];
            CFG_LEVEL:       gain        = data[LEVEL_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_request('0, 1'b0);
        send_request(STEP_MAX, 1'b1);
        send_request(31'h4000_0000, 1'b0);
        send_request(31'h2000_0000, 1'b0);
        send_request(31'h2000_0000, 1'b0);
    endtask

    task automatic test_special_cases();
        // unused waveform code gives silence
        write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_UNUSED));
        send_request(31'h0123_4567, 1'b1);
        // triangle with a positive octave, which must not shift, then both negative octaves
        write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_TRIANGLE));
        write_reg(CFG_OCTAVE, CFG_DATA_W'(OCT_UP));
        send_request(31'h1555_5555, 1'b1);
        send_request(31'h1555_5555, 1'b0);
        write_reg(CFG_OCTAVE, CFG_DATA_W'(OCT_DOWN1));
        send_request(STEP_MAX, 1'b1);
        send_request(STEP_MAX, 1'b0);
        write_reg(CFG_OCTAVE, CFG_DATA_W'(OCT_DOWN2));
        send_request(31'h3000_0001, 1'b1);
        send_request(31'h3000_0001, 1'b0);
        // square above unity level, then muted
        write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
        write_reg(CFG_OCTAVE, CFG_DATA_W'(OCT_NONE));
        write_reg(CFG_LEVEL, CFG_DATA_W'(16'hFFFF));
        send_request(31'h6000_0000, 1'b1);
        send_request(31'h6000_0000, 1'b0);
        write_reg(CFG_LEVEL, '0);
        send_request(31'h0000_1000, 1'b0);
        // coefficient above one, zero coefficient and the smallest one
        write_reg(CFG_LEVEL, CFG_DATA_W'(LEVEL_ONE));
        write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SINE));
        write_reg(CFG_GLIDE_COEFF, CFG_DATA_W'(17'h1FFFF));
        send_request(31'h0ABC_DEF0, 1'b0);
        write_reg(CFG_GLIDE_COEFF, '0);
        send_request('0, 1'b1);
        send_request(31'd5, 1'b0);
        write_reg(CFG_GLIDE_COEFF, CFG_DATA_W'(1));
        send_request(STEP_MAX, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] data;
        logic [STEP_W-1:0]     tgt;
        int                    pick;
        for (int ph = 0; ph < 12; ph++) begin
            // pick a register setting, extremes included
            case ($urandom_range(5))
                0:       data = '0;
                1:       data = CFG_DATA_W'(1);
                2:       data = CFG_DATA_W'(COEFF_ONE);
                3:       data = CFG_DATA_W'($urandom_range(131071, 65537));
                4:       data = CFG_DATA_W'($urandom_range(4096, 1));
                default: data = CFG_DATA_W'($urandom_range(65535));
            endcase
            write_reg(CFG_GLIDE_COEFF, data);
            data      = CFG_DATA_W'($urandom);
            data[1:0] = 2'($urandom_range(3));
            write_reg(CFG_WAVEFORM, data);
            data      = CFG_DATA_W'($urandom);
            data[1:0] = 2'($urandom_range(3));
            write_reg(CFG_OCTAVE, data);
            data = CFG_DATA_W'($urandom);
            case ($urandom_range(3))
                0:       data[LEVEL_W-1:0] = '0;
                1:       data[LEVEL_W-1:0] = LEVEL_ONE;
                2:       data[LEVEL_W-1:0] = '1;
                default: ;
            endcase
            write_reg(CFG_LEVEL, data);
            // cycle through the idling modes
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            for (int n = 0; n < 120; n++) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    tgt = STEP_W'($urandom);
                end else if (pick < 60) begin
                    tgt = model_step + STEP_W'($urandom_range(200)) - STEP_W'(100);
                end else if (pick < 65) begin
                    tgt = model_step;
                end else if (pick < 92) begin
                    tgt = STEP_W'($urandom_range(65535));
                end else if (pick < 96) begin
                    tgt = '0;
                end else begin
                    tgt = STEP_MAX;
                end
                send_request(tgt, $urandom_range(9) == 0);
            end
        end
    endtask

    task automatic test_output_hold_off();
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_asked    = hold_asked + 1;
        for (int n = 0; n < 60; n++) begin
            send_request(STEP_W'($urandom), $urandom_range(3) == 0);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each returned sample with the oldest prediction
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %0d", $time, o_sample);
                mismatches = mismatches + 1;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want, o_sample);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("glide_sub_oscillator_unit test failed");
            $finish;
        end
    end

    initial begin
        // build the sine table from the quarter wave
        for (int a = 0; a < 2**SINE_AW; a++) begin
            int quad, r, pos;
            quad = a / (2**SINE_AW / 4);
            r    = a % (2**SINE_AW / 4);
            pos  = (quad % 2 == 1) ? (2**SINE_AW / 4) - r : r;
            sine_rom[a] = quarter_wave(longint'(pos) << (30 - (SINE_AW - 2)));
            if (quad >= 2) begin
                sine_rom[a] = -sine_rom[a];
            end
        end
        model_phase = '0;
        model_step  = '0;
        glide_coeff = COEFF_ONE;
        wave_sel    = WAVE_SINE;
        oct_code    = OCT_NONE;
        gain        = LEVEL_ONE;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_cases();
        test_random_traffic();
        test_output_hold_off();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("glide_sub_oscillator_unit test passed");
        end else begin
            $display("glide_sub_oscillator_unit test failed");
        end
        $finish;
    end

endmodule
